@@ rtl/core/gfss_pkg.sv @@
`default_nettype none
package gfss_pkg;
	localparam int RateW = 32;
	localparam int TimeW = 48;
	localparam int CfgIdxW = 3;
	localparam logic [31:0] Ln2Q32 = 32'd2977044472;

	typedef enum logic [CfgIdxW-1:0] {
		REG_R12 = 3'd0,
		REG_R23 = 3'd1,
		REG_R34 = 3'd2,
		REG_R41 = 3'd3,
		REG_R31 = 3'd4,
		REG_R21 = 3'd5,
		REG_END = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_NORM, ST_SQ, ST_LN_HI, ST_LN_LO, ST_LN_SUM, ST_DIV, ST_PICK_LO,
		ST_PICK_HI, ST_COMMIT, ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [32:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/gfss_div.sv @@
`default_nettype none
module gfss_div
	import gfss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  div_req_t      req,
	output div_rsp_t      rsp
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [33:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

@@ rtl/core/gillespie_four_state_switch_step_top.sv @@
`default_nettype none
// channel   dir  fields
// s_axis    in   tdata: uniform_time[31:0] uniform_pick[63:32]; tuser: op
// m_axis    out  tdata: species_state[1:0] event_time[49:2]; tuser: step_taken[0] finished[1]
// cfg       in   cfg_index, cfg_data (rate regs 0..5, horizon 6)
// A step goes from one input transfer through normalisation, squaring rounds on the
// shared 33x33 multiplier, the ln 2 scaling, the 64-step restoring divider, pick and
// commit to presenting the result, then back to idle. A restart goes straight to the
// result; an early stop passes only through normalisation before the result.
// Reset: state 1, time 0, not finished, rate and horizon registers zero.
// Input is not ready while an item is in work or its result waits.
module gillespie_four_state_switch_step_top
	import gfss_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [63:0]       s_axis_tdata, // uniform_time, uniform_pick
	input  wire logic              s_axis_tuser, // op
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [55:0]            m_axis_tdata, // species_state, event_time, pad
	output logic [1:0]             m_axis_tuser, // step_taken, finished
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [TimeW-1:0]  cfg_data
);
	logic [RateW-1:0] rate_q [6];
	logic [TimeW-1:0] end_q;
	logic [1:0]       spc_q;
	logic [TimeW-1:0] time_q;
	logic             done_q, taken_q;
	state_t           st_q, st_d;
	logic [31:0]      u_q, pick_q;
	logic [32:0]      m_q;
	logic [31:0]      frac_q;
	logic [4:0]       e_q;
	logic [5:0]       cnt_q;
	logic [63:0]      nl2_q, acc_q, tau_q;
	logic [32:0]      tot_q;
	logic [31:0]      first_q;
	logic [1:0]       to1_q, to2_q;
	logic [32:0]      mul_a, mul_b;
	logic [65:0]      prod;
	logic [65:0]      prod_s1;
	div_req_t         dreq;
	div_rsp_t         drsp;
	logic             in_fire;
	logic [31:0]      r_first, r_second;
	logic [1:0]       t_first, t_second;
	logic [4:0]       msb;
	logic [48:0]      nxt;
	logic [63:0]      ln_sum;

	assign prod = mul_a * mul_b;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign cfg_ready = (st_q == ST_IDLE);
	assign nxt = {1'b0, time_q} + {1'b0, tau_q[47:0]};
	assign ln_sum = acc_q + {32'd0, prod_s1[63:32]};

	gfss_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		msb = 5'd0;
		for (int i = 0; i < 32; i++)
			if (u_q[i]) msb = 5'(i);
	end

	always_comb begin
		r_second = '0;
		t_second = 2'd0;
		unique case (spc_q)
			2'd0: begin r_first = rate_q[REG_R12]; t_first = 2'd1; end
			2'd1: begin r_first = rate_q[REG_R23]; t_first = 2'd2;
				r_second = rate_q[REG_R21]; end
			2'd2: begin r_first = rate_q[REG_R34]; t_first = 2'd3;
				r_second = rate_q[REG_R31]; end
			default: begin r_first = rate_q[REG_R41]; t_first = 2'd0; end
		endcase
	end

	always_comb begin
		mul_a = m_q;
		mul_b = m_q;
		unique case (st_q)
			ST_LN_HI: begin mul_a = {1'b0, nl2_q[63:32]}; mul_b = {1'b0, Ln2Q32}; end
			ST_LN_LO: begin mul_a = {1'b0, nl2_q[31:0]}; mul_b = {1'b0, Ln2Q32}; end
			ST_PICK_LO: begin mul_a = {1'b0, pick_q}; mul_b = {1'b0, tot_q[31:0]}; end
			default: ;
		endcase
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:
				if (in_fire) begin
					if (!s_axis_tuser) st_d = ST_OUT;
					else st_d = ST_NORM;
				end
			ST_NORM: begin
				if (done_q || time_q >= end_q || tot_q == '0 || u_q == '0)
					st_d = ST_OUT;
				else st_d = ST_SQ;
			end
			ST_SQ: if (cnt_q == 6'd32) st_d = ST_LN_HI;
			ST_LN_HI: st_d = ST_LN_LO;
			ST_LN_LO: st_d = ST_LN_SUM;
			ST_LN_SUM: st_d = ST_DIV;
			ST_DIV: if (drsp.done) st_d = ST_PICK_LO;
			ST_PICK_LO: st_d = ST_PICK_HI;
			ST_PICK_HI: st_d = ST_COMMIT;
			ST_COMMIT: st_d = ST_OUT;
			ST_OUT: if (m_axis_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dreq.start    = (st_q == ST_LN_SUM);
		dreq.dividend = {ln_sum[55:0], 8'd0};
		dreq.divisor  = tot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			spc_q <= 2'd1;
			time_q <= '0;
			done_q <= 1'b0;
			taken_q <= 1'b0;
			end_q <= '0;
			for (int i = 0; i < 6; i++) rate_q[i] <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_END) end_q <= cfg_data;
				else if (cfg_index < REG_END) rate_q[cfg_index] <= cfg_data[31:0];
			end
			unique case (st_q)
				ST_IDLE: if (in_fire) begin
					taken_q <= 1'b0;
					if (!s_axis_tuser) begin
						spc_q <= 2'd1;
						time_q <= '0;
						done_q <= 1'b0;
					end
				end
				ST_NORM:
					if (done_q || time_q >= end_q || tot_q == '0 || u_q == '0)
						done_q <= 1'b1;
				ST_COMMIT: begin
					if (nxt > {1'b0, end_q}) done_q <= 1'b1;
					else begin
						time_q <= nxt[47:0];
						spc_q <= ({31'd0, acc_q[32:0]} < {32'd0, first_q}) ? to1_q : to2_q;
						taken_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		unique case (st_q)
			ST_IDLE: if (in_fire) begin
				u_q <= s_axis_tdata[31:0];
				pick_q <= s_axis_tdata[63:32];
				first_q <= r_first;
				to1_q <= t_first;
				to2_q <= t_second;
				tot_q <= {1'b0, r_first} + {1'b0, r_second};
			end
			ST_NORM: begin
				e_q <= msb;
				m_q <= {1'b0, u_q << (5'd31 - msb)};
				frac_q <= '0;
				cnt_q <= '0;
			end
			ST_SQ: if (cnt_q != 6'd32) begin
				cnt_q <= cnt_q + 6'd1;
				frac_q <= {frac_q[30:0], prod[63]};
				m_q <= prod[63] ? {1'b0, prod[63:32]} : prod[63:31];
			end else
				nl2_q <= {26'd0, 6'd32 - {1'b0, e_q}, 32'd0} - {32'd0, frac_q};
			ST_LN_HI: ;
			ST_LN_LO: acc_q <= prod_s1[63:0];
			ST_LN_SUM: acc_q <= ln_sum;
			ST_DIV: if (drsp.done) tau_q <= drsp.quotient;
			ST_PICK_HI: acc_q <= {31'd0, prod_s1[64:32]}
				+ (tot_q[32] ? {32'd0, pick_q} : 64'd0);
			default: ;
		endcase
	end

	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata  = {6'd0, time_q, spc_q};
	assign m_axis_tuser  = {done_q, taken_q};

	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready while result held");
	a_tk: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("taken and finished");
	a_dv: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> st_q == ST_DIV) else $error("stray divide");
endmodule
`default_nettype wire
